// ===== rtl/date_time_text_parser_assert.svh =====
// ----------------------------------------------------------------------------
// date_time_text_parser_assert.svh
// Assertion macros shared by the date/time text parser RTL.
// ----------------------------------------------------------------------------
`ifndef DATE_TIME_TEXT_PARSER_ASSERT_SVH
`define DATE_TIME_TEXT_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// check under reset qualification
`define DTP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// check that also holds across reset
`define DTP_ASSERT_NORST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define DTP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define DTP_ASSERT_NORST(lbl, clk_s, prop, msg)
`endif
`endif

// ===== rtl/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// Types, codes, constants and tables of the date/time text parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // token and number limits
  localparam int TOKEN_CHARS = 5;
  localparam int LEN_W       = $clog2(TOKEN_CHARS + 1);
  localparam int NUM_W       = 17;
  localparam logic [NUM_W-1:0] NUM_MAX = 17'd131071;
  localparam int DAYS_W      = 27;
  localparam int TS_W        = 50;

  // division by 100 as multiply by reciprocal, exact for 17-bit values
  localparam logic [20:0] DIV100_MUL   = 21'd1342178;
  localparam int          DIV100_SHIFT = 27;
  localparam logic [23:0] CS_PER_DAY   = 24'd8640000;
  localparam logic [18:0] CS_PER_HOUR  = 19'd360000;
  localparam logic [12:0] CS_PER_MIN   = 13'd6000;
  localparam logic [6:0]  CS_PER_SEC   = 7'd100;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TOO_LONG    = 4'd1;
  localparam logic [3:0] ST_BAD_NUMBER  = 4'd2;
  localparam logic [3:0] ST_NO_YEAR     = 4'd3;
  localparam logic [3:0] ST_NO_MONTH    = 4'd4;
  localparam logic [3:0] ST_NO_DAY      = 4'd5;
  localparam logic [3:0] ST_BAD_MONTH   = 4'd6;
  localparam logic [3:0] ST_YEAR_ZERO   = 4'd7;
  localparam logic [3:0] ST_BAD_DAY     = 4'd8;
  localparam logic [3:0] ST_NO_HOURS    = 4'd9;
  localparam logic [3:0] ST_NO_MINUTES  = 4'd10;
  localparam logic [3:0] ST_BAD_HOUR    = 4'd11;
  localparam logic [3:0] ST_BAD_MINUTE  = 4'd12;
  localparam logic [3:0] ST_BAD_SECOND  = 4'd13;
  localparam logic [3:0] ST_BAD_CS      = 4'd14;

  // configuration register indexes
  localparam logic CFG_REQ_DATE = 1'b0;
  localparam logic CFG_REQ_TIME = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic take;     // character or end beat accepted
    logic resolve;  // latch date/time fields, clear parse state
    logic load;     // load the result register
  } dtp_cmd_t;

  // days before the first of a month (1..12)
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // days in a month of a common year
  function automatic logic [4:0] days_in(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:                    d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // month number of a three-letter name, 0 when none
  function automatic logic [3:0] month_code(input logic [23:0] s);
    logic [3:0] m;
    case (s)
      "jan":   m = 4'd1;
      "feb":   m = 4'd2;
      "mar":   m = 4'd3;
      "apr":   m = 4'd4;
      "may":   m = 4'd5;
      "jun":   m = 4'd6;
      "jul":   m = 4'd7;
      "aug":   m = 4'd8;
      "sep":   m = 4'd9;
      "oct":   m = 4'd10;
      "nov":   m = 4'd11;
      "dec":   m = 4'd12;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/dtp_if.sv =====
// ----------------------------------------------------------------------------
// dtp_in_if / dtp_out_if
// Valid/ready channels of the date/time text parser.
// ----------------------------------------------------------------------------
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface dtp_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic signed [49:0] timestamp_cs;

  modport source (output valid, output status, output timestamp_cs, input ready);
  modport sink   (input valid, input status, input timestamp_cs, output ready);
endinterface

// ===== rtl/dtp_datapath.sv =====
// ----------------------------------------------------------------------------
// dtp_datapath
// Token assembly, field capture and the stepped timestamp arithmetic.
// ----------------------------------------------------------------------------
module dtp_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_data,
  input  dtp_pkg::dtp_cmd_t    cmd,
  input  logic [7:0]           char_code,
  input  logic                 end_of_text,
  output logic [3:0]           status,
  output logic signed [49:0]   timestamp_cs
);
  import dtp_pkg::*;

  // configuration
  logic req_date_r, req_time_r;

  // parse state
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       ch0_r, ch1_r, ch2_r;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic             dig_r, dig_nxt;
  logic             in_time_r, in_time_nxt;
  logic [2:0]       tcount_r, tcount_nxt;
  logic [NUM_W-1:0] tnum_r [4];
  logic             tnum_we;
  logic [NUM_W-1:0] year_r, year_nxt, first_r, first_nxt, second_r, second_nxt;
  logic [3:0]       month_r, month_nxt;
  logic [3:0]       seen_r, seen_nxt;
  logic             bc_r, bc_nxt;
  logic [3:0]       perr_r, perr_nxt;
  logic             ch_we;

  // character classification
  logic [7:0] c, lc;
  logic       is_colon, is_space, is_punct, is_digit;
  logic [3:0] dval;
  logic [20:0] num_ext;

  always_comb begin
    c        = end_of_text ? CH_SPACE : char_code;
    is_colon = (c == CH_COLON);
    is_space = (c == CH_SPACE);
    is_punct = c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
    lc       = (c inside {[8'd65:8'd90]}) ? c + 8'd32 : c;
    is_digit = lc inside {[8'd48:8'd57]};
    dval     = lc[3:0];
    num_ext  = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0} + {17'd0, dval};
  end

  // token assembly and closing
  always_comb begin
    len_nxt     = len_r;
    num_nxt     = num_r;
    dig_nxt     = dig_r;
    in_time_nxt = in_time_r;
    tcount_nxt  = tcount_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    seen_nxt    = seen_r;
    bc_nxt      = bc_r;
    perr_nxt    = perr_r;
    tnum_we     = 1'b0;
    ch_we       = 1'b0;
    if (cmd.take && perr_r == ST_OK) begin
      if (is_colon || (is_space && in_time_r)) begin
        if (len_r != '0) begin
          in_time_nxt = is_colon;
          len_nxt     = '0;
          if (!dig_r) begin
            perr_nxt = ST_BAD_NUMBER;
          end else if (tcount_r < 3'd4) begin
            tnum_we    = 1'b1;
            tcount_nxt = tcount_r + 3'd1;
          end
        end
      end else if (is_space || is_punct) begin
        if (len_r != '0) begin
          len_nxt = '0;
          if (len_r >= LEN_W'(4)) begin
            if (dig_r) begin
              year_nxt    = num_r;
              seen_nxt[0] = 1'b1;
            end else begin
              perr_nxt = ST_BAD_NUMBER;
            end
          end else if (ch0_r inside {[8'd97:8'd122]}) begin
            if (len_r == LEN_W'(3) && month_code({ch0_r, ch1_r, ch2_r}) != 4'd0) begin
              month_nxt   = month_code({ch0_r, ch1_r, ch2_r});
              seen_nxt[1] = 1'b1;
            end else if (len_r >= LEN_W'(2) && ch0_r == "b" && ch1_r == "c") begin
              bc_nxt = 1'b1;
            end
          end else if (!dig_r) begin
            perr_nxt = ST_BAD_NUMBER;
          end else if (!seen_r[2]) begin
            first_nxt   = num_r;
            seen_nxt[2] = 1'b1;
          end else begin
            second_nxt  = num_r;
            seen_nxt[3] = 1'b1;
          end
        end
      end else if (len_r == LEN_W'(TOKEN_CHARS)) begin
        perr_nxt = ST_TOO_LONG;
        len_nxt  = '0;
      end else begin
        ch_we   = 1'b1;
        len_nxt = len_r + LEN_W'(1);
        if (len_r == '0) begin
          num_nxt = {13'd0, dval};
          dig_nxt = is_digit;
        end else begin
          num_nxt = (num_ext > {4'd0, NUM_MAX}) ? NUM_MAX : num_ext[NUM_W-1:0];
          dig_nxt = dig_r & is_digit;
        end
      end
    end
    if (cmd.resolve) begin
      len_nxt     = '0;
      in_time_nxt = 1'b0;
      tcount_nxt  = '0;
      year_nxt    = '0;
      month_nxt   = '0;
      first_nxt   = '0;
      second_nxt  = '0;
      seen_nxt    = '0;
      bc_nxt      = 1'b0;
      perr_nxt    = ST_OK;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_date_r <= 1'b1;
      req_time_r <= 1'b0;
      len_r      <= '0;
      in_time_r  <= 1'b0;
      tcount_r   <= '0;
      year_r     <= '0;
      month_r    <= '0;
      first_r    <= '0;
      second_r   <= '0;
      seen_r     <= '0;
      bc_r       <= 1'b0;
      perr_r     <= ST_OK;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REQ_DATE: req_date_r <= cfg_data;
          CFG_REQ_TIME: req_time_r <= cfg_data;
          default: ;
        endcase
      end
      len_r     <= len_nxt;
      in_time_r <= in_time_nxt;
      tcount_r  <= tcount_nxt;
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      seen_r    <= seen_nxt;
      bc_r      <= bc_nxt;
      perr_r    <= perr_nxt;
    end
  end

  // token characters and numbers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    dig_r <= dig_nxt;
    if (ch_we) begin
      case (len_r)
        LEN_W'(0): ch0_r <= lc;
        LEN_W'(1): ch1_r <= lc;
        LEN_W'(2): ch2_r <= lc;
        default: ;
      endcase
    end
    if (tnum_we) tnum_r[tcount_r[1:0]] <= num_r;
  end

  // resolve: pick date and time fields, first checks
  logic             hy, hm, hd;
  logic [NUM_W-1:0] yr_s, mon_s, day_s, hr_s, mi_s, se_s, cs_s;
  logic [3:0]       st0_s, tst_s;
  logic [3:0]       st0_r, tst_r;
  logic [NUM_W-1:0] yr_r, i_r, day_r;
  logic [3:0]       mon_r;
  logic             bcf_r;
  logic [4:0]       hr_r;
  logic [5:0]       mi_r, se_r;
  logic [6:0]       cs_r;

  always_comb begin
    hy    = seen_r[0];
    yr_s  = year_r;
    if (seen_r[1]) begin
      hm    = 1'b1;
      mon_s = {13'd0, month_r};
      hd    = seen_r[2];
      day_s = first_r;
    end else begin
      hm    = seen_r[2];
      mon_s = first_r;
      hd    = seen_r[3];
      day_s = second_r;
    end
    if (!req_date_r) begin
      if (!hy) yr_s = 17'd1;
      if (!hm) mon_s = 17'd1;
      if (!hd) day_s = 17'd1;
    end
    if (perr_r != ST_OK)               st0_s = perr_r;
    else if (req_date_r && !hy)        st0_s = ST_NO_YEAR;
    else if (req_date_r && !hm)        st0_s = ST_NO_MONTH;
    else if (req_date_r && !hd)        st0_s = ST_NO_DAY;
    else if (mon_s < 17'd1 || mon_s > 17'd12) st0_s = ST_BAD_MONTH;
    else                               st0_s = ST_OK;
    hr_s = (tcount_r > 3'd0) ? tnum_r[0] : '0;
    mi_s = (tcount_r > 3'd1) ? tnum_r[1] : '0;
    se_s = (tcount_r > 3'd2) ? tnum_r[2] : '0;
    cs_s = (tcount_r > 3'd3) ? tnum_r[3] : '0;
    if (req_time_r && tcount_r < 3'd1)      tst_s = ST_NO_HOURS;
    else if (req_time_r && tcount_r < 3'd2) tst_s = ST_NO_MINUTES;
    else if (cs_s > 17'd99)                 tst_s = ST_BAD_CS;
    else if (se_s > 17'd59)                 tst_s = ST_BAD_SECOND;
    else if (mi_s > 17'd59)                 tst_s = ST_BAD_MINUTE;
    else if (hr_s > 17'd23)                 tst_s = ST_BAD_HOUR;
    else                                    tst_s = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      st0_r <= st0_s;
      tst_r <= tst_s;
      yr_r  <= yr_s;
      i_r   <= bc_r ? yr_s : yr_s - 17'd1;
      mon_r <= mon_s[3:0];
      day_r <= day_s;
      bcf_r <= bc_r;
      hr_r  <= hr_s[4:0];
      mi_r  <= mi_s[5:0];
      se_r  <= se_s[5:0];
      cs_r  <= cs_s[6:0];
    end
  end

  // stage 1: reciprocal and constant products
  logic [37:0] py_r, pi_r;
  logic [35:0] pq_r;
  logic [25:0] i365_r;
  logic [14:0] i4_r;
  logic [23:0] th_r;
  logic [18:0] tm_r;
  logic [12:0] tsec_r;

  always_ff @(posedge clk) begin
    py_r   <= {4'd0, yr_r} * {17'd0, DIV100_MUL};
    pi_r   <= {4'd0, i_r} * {17'd0, DIV100_MUL};
    pq_r   <= {2'd0, i_r[NUM_W-1:2]} * {15'd0, DIV100_MUL};
    i365_r <= {9'd0, i_r} * 26'd365;
    i4_r   <= i_r[NUM_W-1:2];
    th_r   <= {19'd0, hr_r} * {5'd0, CS_PER_HOUR};
    tm_r   <= {13'd0, mi_r} * {6'd0, CS_PER_MIN};
    tsec_r <= {7'd0, se_r} * {6'd0, CS_PER_SEC};
  end

  // stage 2: leap year, day check, years to days, time of day
  logic [10:0] qy, qi100;
  logic [8:0]  qi400;
  logic        leap_s;
  logic [4:0]  dim;
  logic [25:0] days_r;
  logic        leap_r;
  logic [3:0]  e78_r;
  logic [23:0] tsum_r;

  always_comb begin
    qy     = py_r[DIV100_SHIFT +: 11];
    qi100  = pi_r[DIV100_SHIFT +: 11];
    qi400  = pq_r[DIV100_SHIFT +: 9];
    leap_s = (yr_r[1:0] == 2'b00) &&
             ((yr_r != ({6'd0, qy} * 17'd100)) || (qy[1:0] == 2'b00));
    dim    = days_in(mon_r) + {4'd0, (mon_r == 4'd2) && leap_s};
  end

  always_ff @(posedge clk) begin
    days_r <= i365_r + {11'd0, i4_r} - {15'd0, qi100} + {17'd0, qi400};
    leap_r <= leap_s;
    if (day_r == '0 || day_r > {12'd0, dim}) e78_r <= ST_BAD_DAY;
    else if (yr_r == '0)                    e78_r <= ST_YEAR_ZERO;
    else                                    e78_r <= ST_OK;
    tsum_r <= th_r + {5'd0, tm_r} + {11'd0, tsec_r} + {17'd0, cs_r};
  end

  // stage 3: signed day number
  logic signed [DAYS_W-1:0] dsign, dd_r;

  always_comb begin
    dsign = bcf_r ? -$signed({1'b0, days_r}) : $signed({1'b0, days_r});
  end

  always_ff @(posedge clk) begin
    dd_r <= dsign + $signed({18'd0, days_before(mon_r)})
          + $signed({26'd0, (mon_r >= 4'd3) && leap_r})
          + $signed({22'd0, day_r[4:0]}) - $signed(27'd1);
  end

  // stage 4: days to centiseconds
  logic signed [51:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= dd_r * $signed({1'b0, CS_PER_DAY});
  end

  // result register
  logic [3:0] st_fin;

  always_comb begin
    if (st0_r != ST_OK)      st_fin = st0_r;
    else if (e78_r != ST_OK) st_fin = e78_r;
    else                     st_fin = tst_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= st_fin;
      timestamp_cs <= (st_fin == ST_OK) ?
                      prod_r[TS_W-1:0] + $signed({26'd0, tsum_r}) : '0;
    end
  end

endmodule

// ===== rtl/dtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtp_ctrl
// Sequencer for character intake, the result steps and the output beat.
// ----------------------------------------------------------------------------
module dtp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_end,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dtp_pkg::dtp_cmd_t  cmd
);
  import dtp_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RESOLVE = 3'd1;
  localparam logic [2:0] S_MUL     = 3'd2;
  localparam logic [2:0] S_DAYS    = 3'd3;
  localparam logic [2:0] S_SIGN    = 3'd4;
  localparam logic [2:0] S_SCALE   = 3'd5;
  localparam logic [2:0] S_LOAD    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign load        = (state_r == S_LOAD) && (!out_valid_r || out_ready);
  assign cmd.take    = in_valid && in_ready;
  assign cmd.resolve = (state_r == S_RESOLVE);
  assign cmd.load    = load;

  // next state
  always_comb begin
    case (state_r)
      S_IDLE:    state_nxt = (in_valid && in_end) ? S_RESOLVE : S_IDLE;
      S_RESOLVE: state_nxt = S_MUL;
      S_MUL:     state_nxt = S_DAYS;
      S_DAYS:    state_nxt = S_SIGN;
      S_SIGN:    state_nxt = S_SCALE;
      S_SCALE:   state_nxt = S_LOAD;
      S_LOAD:    state_nxt = load ? S_IDLE : S_LOAD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // output beat pending
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/date_time_text_parser.sv =====
// ----------------------------------------------------------------------------
// date_time_text_parser
// Turns a streamed date/time text into a status and signed centiseconds.
// ----------------------------------------------------------------------------
// Text streams in at one character per clock while the parser is idle.
// The end beat closes the last token and starts the result sequence: a
// resolve step picks the fields, four arithmetic steps (reciprocal
// products, leap year and day count, sign and month offset, scaling by
// centiseconds per day) follow, then the result register is loaded and
// the next character is taken from then on. The result register holds
// one beat; a further end beat waits in the load step until that beat is
// taken. Configuration writes take effect at once; the user must make them
// only while no text is in progress, and the block does not enforce this.
`include "date_time_text_parser_assert.svh"

module date_time_text_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  dtp_in_if.sink     in_if,
  dtp_out_if.source  out_if
);
  import dtp_pkg::*;

  dtp_cmd_t cmd;

  dtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_end    (in_if.end_of_text),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  dtp_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .char_code    (in_if.char_code),
    .end_of_text  (in_if.end_of_text),
    .status       (out_if.status),
    .timestamp_cs (out_if.timestamp_cs)
  );

  // intake stops while a result is being formed
  `DTP_ASSERT(a_end_blocks_intake, clk, rst_n, in_if.valid && in_if.ready && in_if.end_of_text |=> !in_if.ready, "input taken during result sequence")
  // failed results carry a zero timestamp
  `DTP_ASSERT(a_err_zero_ts, clk, rst_n, out_if.valid && out_if.status != ST_OK |-> out_if.timestamp_cs == '0, "nonzero timestamp with error status")
  // status stays within defined codes
  `DTP_ASSERT(a_status_range, clk, rst_n, out_if.valid |-> out_if.status <= ST_BAD_CS, "undefined status code")
  // reset leaves no result beat pending
  `DTP_ASSERT_NORST(a_reset_clears_out, clk, !rst_n |=> !out_if.valid, "result beat after reset")

endmodule
